@@ hdl/ttcd_pkg.sv @@
// ----------------------------------------------------------------------------
// ttcd_pkg
// Shared types, constants and the microcode table for the tick count to
// calendar date converter.
// ----------------------------------------------------------------------------
package ttcd_pkg;

   localparam int TICK_W  = 22;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 15;   // whole days since epoch, at most 29127
   localparam int DOM_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int TOD_W   = 8;    // tick within the day, 0..143
   localparam int STEP_W  = 3;

   // ticks / 144 = (ticks >> 4) / 9, taken as (q * ceil(2^22 / 9)) >> 22
   localparam int DIV9_SHIFT = 22;
   localparam logic [18:0] DIV9_RECIP = 19'd466034;
   // tod / 6 = (tod * 171) >> 10 for tod below 144
   localparam int DIV6_SHIFT = 10;
   localparam logic [7:0] DIV6_RECIP = 8'd171;

   localparam logic [TICK_W-1:0]  TICKS_PER_DAY = 22'd144;
   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
   localparam logic [MONTH_W-1:0] JANUARY       = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY      = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER      = 4'd12;
   localparam logic [8:0]         DAYS_YEAR     = 9'd365;
   localparam logic [8:0]         DAYS_LEAP     = 9'd366;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_DIVIDE,
      OP_SPLIT,
      OP_YEAR,
      OP_MONTH,
      OP_EMIT
   } op_type;

   // condition under which a step repeats instead of going to its successor
   typedef enum logic [1:0] {
      HOLD_NONE,
      HOLD_NO_REQ,
      HOLD_MORE,
      HOLD_OUT_FULL
   } hold_type;

   typedef struct packed {
      op_type              op;
      hold_type            hold;
      logic [STEP_W-1:0]   next_step;
   } ctrl_word_type;

   typedef struct packed {
      logic req_pending;
      logic more;
      logic out_full;
   } status_type;

   localparam logic [STEP_W-1:0] STEP_LOAD   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_DIVIDE = 3'd1;
   localparam logic [STEP_W-1:0] STEP_SPLIT  = 3'd2;
   localparam logic [STEP_W-1:0] STEP_YEAR   = 3'd3;
   localparam logic [STEP_W-1:0] STEP_MONTH  = 3'd4;
   localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd5;

   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      case (step)
         STEP_LOAD:   cw = '{OP_LOAD,   HOLD_NO_REQ,   STEP_DIVIDE};
         STEP_DIVIDE: cw = '{OP_DIVIDE, HOLD_NONE,     STEP_SPLIT};
         STEP_SPLIT:  cw = '{OP_SPLIT,  HOLD_NONE,     STEP_YEAR};
         STEP_YEAR:   cw = '{OP_YEAR,   HOLD_MORE,     STEP_MONTH};
         STEP_MONTH:  cw = '{OP_MONTH,  HOLD_MORE,     STEP_EMIT};
         STEP_EMIT:   cw = '{OP_EMIT,   HOLD_OUT_FULL, STEP_LOAD};
         default:     cw = '{OP_LOAD,   HOLD_NONE,     STEP_LOAD};
      endcase
      return cw;
   endfunction

   // low two bits decide leap years across the whole reachable range 1970..2049
   function automatic logic is_leap(input logic [YEAR_W-1:0] year);
      return (year[1:0] == 2'b00);
   endfunction

   function automatic logic [DOM_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                   input logic leap);
      logic [DOM_W-1:0] len;
      case (month) inside
         FEBRUARY:                  len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ hdl/ttcd_seq.sv @@
// ----------------------------------------------------------------------------
// ttcd_seq
// Step counter and microcode table; repeats a step while its hold condition
// is true, otherwise jumps to the step named in the control word.
// ----------------------------------------------------------------------------
module ttcd_seq (
   input  logic                   clock,
   input  logic                   reset,
   input  ttcd_pkg::status_type   status,
   output ttcd_pkg::ctrl_word_type cw
);
   import ttcd_pkg::*;

   logic [STEP_W-1:0] step_ff;
   logic [STEP_W-1:0] step_in;
   logic              hold;

   assign cw = ucode(step_ff);

   always_comb begin
      case (cw.hold)
         HOLD_NONE:     hold = 1'b0;
         HOLD_NO_REQ:   hold = !status.req_pending;
         HOLD_MORE:     hold = status.more;
         HOLD_OUT_FULL: hold = status.out_full;
         default:       hold = 1'b0;
      endcase
   end

   assign step_in = hold ? step_ff : cw.next_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

@@ hdl/ttcd_datapath.sv @@
// ----------------------------------------------------------------------------
// ttcd_datapath
// Registers and arithmetic for the conversion, driven one control word per
// cycle: load, divide into days, split time of day, walk years, walk months,
// emit.
// ----------------------------------------------------------------------------
module ttcd_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ttcd_pkg::ctrl_word_type           cw,
   output ttcd_pkg::status_type              status,
   input  logic                              req_valid,
   input  logic [ttcd_pkg::TICK_W-1:0]       req_tick_count,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [ttcd_pkg::YEAR_W-1:0]       rsp_year,
   output logic [ttcd_pkg::MONTH_W-1:0]      rsp_month,
   output logic [ttcd_pkg::DOM_W-1:0]        rsp_day_of_month,
   output logic [ttcd_pkg::HOUR_W-1:0]       rsp_hour,
   output logic [ttcd_pkg::MIN_W-1:0]        rsp_minute,
   output logic [ttcd_pkg::SEC_W-1:0]        rsp_second
);
   import ttcd_pkg::*;

   logic [TICK_W-1:0]  tick_ff,  tick_in;
   logic [DAY_W-1:0]   day_ff,   day_in;
   logic [HOUR_W-1:0]  hour_ff,  hour_in;
   logic [MIN_W-1:0]   minute_ff, minute_in;
   logic [YEAR_W-1:0]  year_ff,  year_in;
   logic [MONTH_W-1:0] month_ff, month_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [YEAR_W-1:0]     rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]    rsp_month_ff, rsp_month_in;
   logic [DOM_W-1:0]      rsp_dom_ff, rsp_dom_in;
   logic [HOUR_W-1:0]     rsp_hour_ff, rsp_hour_in;
   logic [MIN_W-1:0]      rsp_minute_ff, rsp_minute_in;

   logic [36:0]       div_prod;
   logic [TICK_W-1:0] day_ticks;
   logic [TICK_W-1:0] tod_full;
   logic [TOD_W-1:0]  tod;
   logic [15:0]       hour_prod;
   logic [HOUR_W-1:0] hour_calc;
   logic [TOD_W-1:0]  tick_in_hour;
   logic [MIN_W-1:0]  minute_calc;
   logic              leap;
   logic [8:0]        year_len;
   logic [DOM_W-1:0]  month_len;
   logic              year_more;
   logic              month_more;
   logic              out_free;

   // days = (tick >> 4) / 9
   assign div_prod  = {19'd0, tick_ff[TICK_W-1:4]} * {18'd0, DIV9_RECIP};

   // tick within the day and its hour / minute split
   assign day_ticks    = {day_ff, 7'd0} + {3'd0, day_ff, 4'd0};
   assign tod_full     = tick_ff - day_ticks;
   assign tod          = tod_full[TOD_W-1:0];
   assign hour_prod    = {8'd0, tod} * {8'd0, DIV6_RECIP};
   assign hour_calc    = hour_prod[DIV6_SHIFT+HOUR_W-1:DIV6_SHIFT];
   assign tick_in_hour = tod - ({1'b0, hour_calc, 2'd0} + {2'd0, hour_calc, 1'b0});
   // 10 minutes per tick
   assign minute_calc  = {tick_in_hour[2:0], 3'd0} + {1'b0, tick_in_hour[2:0], 2'd0}
                       - {2'd0, tick_in_hour[2:0], 1'b0};

   assign leap       = is_leap(year_ff);
   assign year_len   = leap ? DAYS_LEAP : DAYS_YEAR;
   assign month_len  = month_days(month_ff, leap);
   assign year_more  = (day_ff >= {{(DAY_W-9){1'b0}}, year_len});
   assign month_more = (month_ff < DECEMBER)
                     && (day_ff >= {{(DAY_W-DOM_W){1'b0}}, month_len});

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.req_pending = req_valid;
      status.out_full    = !out_free;
      case (cw.op)
         OP_YEAR:  status.more = year_more;
         OP_MONTH: status.more = month_more;
         default:  status.more = 1'b0;
      endcase
   end

   always_comb begin
      tick_in       = tick_ff;
      day_in        = day_ff;
      hour_in       = hour_ff;
      minute_in     = minute_ff;
      year_in       = year_ff;
      month_in      = month_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_dom_in    = rsp_dom_ff;
      rsp_hour_in   = rsp_hour_ff;
      rsp_minute_in = rsp_minute_ff;
      // drop the result once it is taken
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      case (cw.op)
         OP_LOAD: begin
            if (req_valid) begin
               tick_in = req_tick_count;
            end
         end
         OP_DIVIDE: begin
            day_in = div_prod[DIV9_SHIFT+DAY_W-1:DIV9_SHIFT];
         end
         OP_SPLIT: begin
            hour_in   = hour_calc;
            minute_in = minute_calc;
            year_in   = EPOCH_YEAR;
            month_in  = JANUARY;
         end
         OP_YEAR: begin
            if (year_more) begin
               day_in  = day_ff - {{(DAY_W-9){1'b0}}, year_len};
               year_in = year_ff + 12'd1;
            end
         end
         OP_MONTH: begin
            if (month_more) begin
               day_in   = day_ff - {{(DAY_W-DOM_W){1'b0}}, month_len};
               month_in = month_ff + 4'd1;
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_year_in   = year_ff;
               rsp_month_in  = month_ff;
               rsp_dom_in    = day_ff[DOM_W-1:0] + 5'd1;
               rsp_hour_in   = hour_ff;
               rsp_minute_in = minute_ff;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tick_ff       <= tick_in;
      day_ff        <= day_in;
      hour_ff       <= hour_in;
      minute_ff     <= minute_in;
      year_ff       <= year_in;
      month_ff      <= month_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_dom_ff    <= rsp_dom_in;
      rsp_hour_ff   <= rsp_hour_in;
      rsp_minute_ff <= rsp_minute_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_day_of_month = rsp_dom_ff;
   assign rsp_hour         = rsp_hour_ff;
   assign rsp_minute       = rsp_minute_ff;
   // resolution is 10 minutes, so seconds are always zero
   assign rsp_second       = '0;

endmodule

@@ hdl/tick_count_to_calendar_date.sv @@
// ----------------------------------------------------------------------------
// tick_count_to_calendar_date
// Converts a count of 10-minute ticks since 1970-01-01 00:00 into a
// Gregorian date and time of day.
//
// Request channel: req_valid / req_stall with req_tick_count. A request is
// taken when req_valid is high and req_stall is low; req_stall is low only
// while the sequencer sits in its load step.
// Response channel: rsp_valid / rsp_stall with year, month, day of month,
// hour, minute and second. One response per request, in order.
// Sequencing: a microcoded sequencer runs load, divide, split, then repeats
// the year step from 1970 while a whole year remains in the day count, repeats
// the month step while a whole month remains and December is not reached,
// then runs emit. One item is in work at a time: the next request is taken
// only after the emit step, once the sequencer is back in its load step.
// The response sits in an output register, so the next request is taken
// while a result still waits; if the receiver stalls the waiting result,
// the sequencer holds in its emit step until that register frees up.
// Reset (synchronous, active high) returns the sequencer to the load step
// and drops any pending response.
// ----------------------------------------------------------------------------
module tick_count_to_calendar_date (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ttcd_pkg::TICK_W-1:0]       req_tick_count,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ttcd_pkg::YEAR_W-1:0]       rsp_year,
   output logic [ttcd_pkg::MONTH_W-1:0]      rsp_month,
   output logic [ttcd_pkg::DOM_W-1:0]        rsp_day_of_month,
   output logic [ttcd_pkg::HOUR_W-1:0]       rsp_hour,
   output logic [ttcd_pkg::MIN_W-1:0]        rsp_minute,
   output logic [ttcd_pkg::SEC_W-1:0]        rsp_second
);
   import ttcd_pkg::*;

   ctrl_word_type cw;
   status_type    status;

   assign req_stall = (cw.op != OP_LOAD);

   ttcd_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cw     (cw)
   );

   ttcd_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cw               (cw),
      .status           (status),
      .req_valid        (req_valid),
      .req_tick_count   (req_tick_count),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

endmodule
